// ===== src/psrq_pkg.sv =====
// Shared types and constants for the packet slot ring queue.
package psrq_pkg;

   // Command carried in the input tuser field
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_POP   = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   // Largest length that the length table can record
   localparam logic [8:0] LEN_MAX = 9'd511;

   // Result item as packed on rsp_tdata, lowest field in the lowest bits
   typedef struct packed {
      logic       queue_empty;
      logic       overflow_dropped;
      logic       pop_was_empty;
      logic [8:0] packet_length;
      logic [3:0] packet_slot;
      logic [7:0] read_byte;
   } rsp_type;

   // Item bookkeeping held while its memory read completes
   typedef struct packed {
      logic       is_read;
      logic       is_pop;
      logic [3:0] pop_slot;
      logic       was_empty;
      logic       dropped;
      logic       empty_after;
   } pend_type;

endpackage

// ===== src/psrq_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module psrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the entry, register the read data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/packet_slot_ring_queue.sv =====
// Top level of the packet slot ring queue: pointers, memories and result stage.
// A result passes through the pending stage, with its memory read, and then the output register.
// Throughput: one item per cycle unless results stall; an item accesses each memory at most once.
// Reset clears head, tail, write offset and the pending and output stages.
// Byte store and length table are not cleared; there is no clearing pass after reset.
module packet_slot_ring_queue #(
   parameter int SLOT_COUNT = 16,
   parameter int SLOT_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // data_byte [7:0], slot_index [11:8], byte_offset [19:12], zero [23:20]
   input  logic [23:0] req_tdata,
   input  logic        req_tlast,
   // cmd [1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_byte [7:0], packet_slot [11:8], packet_length [20:12], pop_was_empty [21],
   // overflow_dropped [22], queue_empty [23]
   output logic [23:0] rsp_tdata
);

   localparam int PW = $clog2(SLOT_COUNT);
   localparam int OW = $clog2(SLOT_BYTES + 1);
   localparam int STORE_DEPTH = SLOT_COUNT * SLOT_BYTES;
   localparam int AW = $clog2(STORE_DEPTH);

   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [OW-1:0] wo_ff, wo_in;
   logic [OW-1:0] wo_next;

   logic                 pend_valid_ff, pend_valid_in;
   psrq_pkg::pend_type   pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   psrq_pkg::rsp_type    rsp_ff, rsp_in;

   logic accept;
   logic pend_adv;

   psrq_pkg::cmd_type cmd;
   logic [7:0] req_byte;
   logic [3:0] req_slot;
   logic [7:0] req_off;

   logic          store_we, store_re;
   logic [AW-1:0] store_waddr, store_raddr;
   logic [7:0]    store_rdata;
   logic          len_we, len_re;
   logic [8:0]    len_wdata, len_rdata;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] s);
      next_slot = (s == PW'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
   endfunction

   // Unpack the input item
   assign cmd      = psrq_pkg::cmd_type'(req_tuser);
   assign req_byte = req_tdata[7:0];
   assign req_slot = req_tdata[11:8];
   assign req_off  = req_tdata[19:12];

   // Advance the pending item when the output register is free or being taken
   assign pend_adv   = pend_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !pend_valid_ff || pend_adv;
   assign accept     = req_tvalid && req_tready;

   assign wo_next     = wo_ff + 1'b1;
   assign store_waddr = AW'(tail_ff) * AW'(SLOT_BYTES) + AW'(wo_ff);
   assign store_raddr = AW'(req_slot) * AW'(SLOT_BYTES) + AW'(req_off);

   // Decode the item: pointer updates, memory accesses, pending bookkeeping
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      wo_in     = wo_ff;
      store_we  = 1'b0;
      store_re  = 1'b0;
      len_we    = 1'b0;
      len_re    = 1'b0;
      len_wdata = '0;
      pend_in   = '0;
      if (accept) begin
         case (cmd)
            psrq_pkg::CMD_WRITE: begin
               if (32'(wo_ff) < SLOT_BYTES) begin
                  store_we = 1'b1;
                  wo_in    = wo_next;
               end else begin
                  pend_in.dropped = 1'b1;
               end
               if (req_tlast) begin
                  // Close the packet: record saturated length, move the tail
                  len_we = 1'b1;
                  if (32'(wo_in) > 32'(psrq_pkg::LEN_MAX)) begin
                     len_wdata = psrq_pkg::LEN_MAX;
                  end else begin
                     len_wdata = 9'(wo_in);
                  end
                  tail_in = next_slot(tail_ff);
                  wo_in   = '0;
               end
            end
            psrq_pkg::CMD_POP: begin
               if (head_ff == tail_ff) begin
                  pend_in.was_empty = 1'b1;
               end else begin
                  pend_in.is_pop   = 1'b1;
                  pend_in.pop_slot = 4'(head_ff);
                  len_re           = 1'b1;
                  head_in          = next_slot(head_ff);
               end
            end
            psrq_pkg::CMD_READ: begin
               if (32'(req_slot) < SLOT_COUNT && 32'(req_off) < SLOT_BYTES) begin
                  store_re        = 1'b1;
                  pend_in.is_read = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      pend_in.empty_after = (head_in == tail_in);
   end

   // Assemble the result from the pending item and the memory read data
   always_comb begin
      rsp_in                  = '0;
      rsp_in.read_byte        = pend_ff.is_read ? store_rdata : 8'd0;
      rsp_in.packet_slot      = pend_ff.pop_slot;
      rsp_in.packet_length    = pend_ff.is_pop ? len_rdata : 9'd0;
      rsp_in.pop_was_empty    = pend_ff.was_empty;
      rsp_in.overflow_dropped = pend_ff.dropped;
      rsp_in.queue_empty      = pend_ff.empty_after;
   end

   // Hold or advance the pending and output stage valids
   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (accept) begin
         pend_valid_in = 1'b1;
      end else if (pend_adv) begin
         pend_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (pend_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         wo_ff         <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         wo_ff         <= wo_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (pend_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   // Packet byte store
   psrq_ram #(
      .WIDTH(8),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (store_we),
      .wr_addr(store_waddr),
      .wr_data(req_byte),
      .rd_en  (store_re),
      .rd_addr(store_raddr),
      .rd_data(store_rdata)
   );

   // Per-slot packet length table
   psrq_ram #(
      .WIDTH(9),
      .DEPTH(SLOT_COUNT)
   ) u_length (
      .clock  (clock),
      .wr_en  (len_we),
      .wr_addr(tail_ff),
      .wr_data(len_wdata),
      .rd_en  (len_re),
      .rd_addr(head_ff),
      .rd_data(len_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   // Write offset never runs past the slot size
   assert property (@(posedge clock) disable iff (reset) 32'(wo_ff) <= SLOT_BYTES)
      else $error("write offset beyond slot size");

   // A stalled pending item keeps its bookkeeping
   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && !pend_adv |=> pend_valid_ff && $stable(pend_ff))
      else $error("pending item lost while stalled");

   // A pop on an empty queue leaves the head alone
   assert property (@(posedge clock) disable iff (reset)
      accept && cmd == psrq_pkg::CMD_POP && head_ff == tail_ff |=> $stable(head_ff))
      else $error("head moved on empty pop");

   // An empty pop reports zero length and an empty queue
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.pop_was_empty |-> rsp_ff.queue_empty && rsp_ff.packet_length == 9'd0)
      else $error("empty pop result inconsistent");

endmodule

// ===== bench/ring_queue_checker.sv =====
// Result checker for the packet slot ring queue: predicts every result and compares it.
module ring_queue_checker #(
   parameter int SLOT_COUNT = 16,
   parameter int SLOT_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // data_byte [7:0], slot_index [11:8], byte_offset [19:12], zero [23:20]
   input  logic [23:0] req_tdata,
   input  logic        req_tlast,
   // cmd [1:0]
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_byte [7:0], packet_slot [11:8], packet_length [20:12], pop_was_empty [21],
   // overflow_dropped [22], queue_empty [23]
   input  logic [23:0] rsp_tdata,
   output int          error_count,
   output int          pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the ring: byte store, lengths and pointers
   logic [7:0]  byte_store [SLOT_COUNT][SLOT_BYTES];
   logic [8:0]  slot_length [SLOT_COUNT];
   int unsigned head_slot = 0;
   int unsigned tail_slot = 0;
   int unsigned write_offset = 0;

   // Results predicted and not yet seen on the output
   psrq_pkg::rsp_type expected_results[$];

   function automatic int unsigned next_slot(int unsigned slot);
      return (slot >= SLOT_COUNT - 1) ? 0 : slot + 1;
   endfunction

   // Apply one item to the shadow ring and return the result it must produce
   function automatic psrq_pkg::rsp_type ring_result(logic [1:0] cmd, logic [7:0] data,
                                                     logic eop, logic [3:0] slot,
                                                     logic [7:0] offset);
      psrq_pkg::rsp_type r;
      int unsigned       len;
      r = '0;
      case (cmd)
         psrq_pkg::CMD_WRITE: begin
            if (write_offset < SLOT_BYTES) begin
               byte_store[tail_slot][write_offset] = data;
               write_offset++;
            end else begin
               r.overflow_dropped = 1'b1;
            end
            // close the packet even when its last byte was dropped
            if (eop) begin
               len = (write_offset > psrq_pkg::LEN_MAX) ? psrq_pkg::LEN_MAX : write_offset;
               slot_length[tail_slot] = len[8:0];
               tail_slot = next_slot(tail_slot);
               write_offset = 0;
            end
         end
         psrq_pkg::CMD_POP: begin
            if (head_slot == tail_slot) begin
               r.pop_was_empty = 1'b1;
            end else begin
               r.packet_slot = head_slot[3:0];
               r.packet_length = slot_length[head_slot];
               head_slot = next_slot(head_slot);
            end
         end
         psrq_pkg::CMD_READ: begin
            if (slot < SLOT_COUNT && offset < SLOT_BYTES)
               r.read_byte = byte_store[slot][offset];
         end
         default: ;
      endcase
      r.queue_empty = (head_slot == tail_slot);
      return r;
   endfunction

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // Queue a prediction per accepted item, compare each accepted result
   always @(posedge clock) begin
      psrq_pkg::rsp_type want;
      psrq_pkg::rsp_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_results.push_back(ring_result(req_tuser, req_tdata[7:0], req_tlast,
                                                   req_tdata[11:8], req_tdata[19:12]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t unexpected result: expected none, actual %h", $time, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               check_field("read_byte", want.read_byte, got.read_byte);
               check_field("packet_slot", want.packet_slot, got.packet_slot);
               check_field("packet_length", want.packet_length, got.packet_length);
               check_field("pop_was_empty", want.pop_was_empty, got.pop_was_empty);
               check_field("overflow_dropped", want.overflow_dropped, got.overflow_dropped);
               check_field("queue_empty", want.queue_empty, got.queue_empty);
            end
         end
         pending_results <= expected_results.size();
      end
   end

endmodule

// ===== bench/testbench.sv =====
// Top of the packet slot ring queue bench: clock, reset, item stimulus and verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_COUNT     = 16;
   localparam int SLOT_BYTES     = 256;
   localparam int ITEM_TOTAL     = 1100;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_GAP        = 20;
   localparam int DRAIN_CYCLES   = 8;
   localparam int LONG_PACKET    = 260;
   localparam int LONG_AT        = 450;
   // cmd code with no operation behind it
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   int          error_count;
   int          pending_results;

   // Idle rates of the current phase, in percent
   int send_idle_pct = 0;
   int stall_pct = 0;
   int items_sent = 0;
   int idle_cycles = 0;

   // Fill tracking so that reads only touch bytes already written
   int unsigned fill_tail = 0;
   int unsigned fill_offset = 0;
   int          written_extent [SLOT_COUNT] = '{default: 0};

   packet_slot_ring_queue #(
      .SLOT_COUNT(SLOT_COUNT),
      .SLOT_BYTES(SLOT_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   ring_queue_checker #(
      .SLOT_COUNT(SLOT_COUNT),
      .SLOT_BYTES(SLOT_BYTES)
   ) result_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .error_count    (error_count),
      .pending_results(pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Stall the result side at the phase's rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // End the run when no item moves on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one item, hold it until accepted, and track which bytes are written
   task automatic send_item(logic [1:0] cmd, logic [7:0] data, logic eop,
                            logic [3:0] slot, logic [7:0] offset);
      int gap;
      gap = 0;
      case (items_sent * 5 / ITEM_TOTAL)
         1: begin
            send_idle_pct = 75;
            stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct = 75;
         end
         3: begin
            send_idle_pct = 35;
            stall_pct = 35;
         end
         default: begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
      endcase
      while (send_idle_pct != 0 && gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         gap++;
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tlast <= eop;
      req_tdata <= {4'h0, offset, slot, data};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (cmd == psrq_pkg::CMD_WRITE) begin
         if (fill_offset < SLOT_BYTES) begin
            if (written_extent[fill_tail] < fill_offset + 1)
               written_extent[fill_tail] = fill_offset + 1;
            fill_offset++;
         end
         if (eop) begin
            fill_tail = (fill_tail == SLOT_COUNT - 1) ? 0 : fill_tail + 1;
            fill_offset = 0;
         end
      end
   endtask

   initial begin
      int i;
      int k;
      int len;
      int pick;
      int count;
      int long_slot;
      int read_slot;
      bit long_done;
      int candidates[$];
      long_done = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pop, unused command, short packets, reads, pops to empty
      send_item(psrq_pkg::CMD_POP, 8'h00, 1'b0, 4'h0, 8'h00);
      send_item(CMD_UNUSED, 8'hFF, 1'b1, 4'hF, 8'hFF);
      send_item(psrq_pkg::CMD_WRITE, 8'h00, 1'b0, 4'h0, 8'h00);
      send_item(psrq_pkg::CMD_WRITE, 8'hFF, 1'b0, 4'hF, 8'hFF);
      send_item(psrq_pkg::CMD_WRITE, 8'h5A, 1'b1, 4'h0, 8'h00);
      send_item(psrq_pkg::CMD_READ, 8'h00, 1'b0, 4'h0, 8'h00);
      send_item(psrq_pkg::CMD_READ, 8'hFF, 1'b1, 4'h0, 8'h02);
      send_item(psrq_pkg::CMD_WRITE, 8'hA5, 1'b1, 4'h0, 8'h00);
      send_item(psrq_pkg::CMD_POP, 8'hFF, 1'b1, 4'hF, 8'hFF);
      send_item(psrq_pkg::CMD_POP, 8'h00, 1'b0, 4'h0, 8'h00);
      send_item(psrq_pkg::CMD_POP, 8'h00, 1'b0, 4'h0, 8'h00);
      send_item(psrq_pkg::CMD_READ, 8'h00, 1'b0, 4'h1, 8'h00);
      send_item(psrq_pkg::CMD_WRITE, 8'h81, 1'b1, 4'h0, 8'h00);
      send_item(psrq_pkg::CMD_READ, 8'h00, 1'b0, 4'h2, 8'h00);
      send_item(psrq_pkg::CMD_POP, 8'h00, 1'b1, 4'h0, 8'h00);
      send_item(CMD_UNUSED, 8'h00, 1'b0, 4'h0, 8'h00);

      // Random: packets, pops, reads of written bytes, ring-wrapping bursts, noise
      while (items_sent < ITEM_TOTAL) begin
         // one packet longer than a slot: overflow, then close on a dropped byte
         if (!long_done && items_sent >= LONG_AT) begin
            long_slot = fill_tail;
            for (i = 0; i < LONG_PACKET; i++)
               send_item(psrq_pkg::CMD_WRITE, $urandom, i == LONG_PACKET - 1,
                         $urandom, $urandom);
            send_item(psrq_pkg::CMD_READ, $urandom, $urandom, long_slot, 8'hFF);
            send_item(psrq_pkg::CMD_READ, $urandom, $urandom, long_slot, 8'h00);
            send_item(psrq_pkg::CMD_READ, $urandom, $urandom, long_slot, 8'h80);
            long_done = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            // a full ring of one-byte packets makes the queue look empty
            count = $urandom_range(SLOT_COUNT, SLOT_COUNT + 1);
            for (i = 0; i < count; i++)
               send_item(psrq_pkg::CMD_WRITE, $urandom, 1'b1, $urandom, $urandom);
         end else if (pick < 52) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            // now and then leave the end mark off so the packet runs on
            for (i = 0; i < len; i++)
               send_item(psrq_pkg::CMD_WRITE, $urandom,
                         (i == len - 1) && ($urandom_range(0, 19) != 0), $urandom, $urandom);
         end else if (pick < 78) begin
            count = $urandom_range(1, 3);
            for (i = 0; i < count; i++)
               send_item(psrq_pkg::CMD_POP, $urandom, $urandom, $urandom, $urandom);
         end else if (pick < 95) begin
            candidates.delete();
            for (k = 0; k < SLOT_COUNT; k++)
               if (written_extent[k] > 0)
                  candidates.push_back(k);
            if (candidates.size() > 0) begin
               count = $urandom_range(1, 4);
               for (i = 0; i < count; i++) begin
                  read_slot = candidates[$urandom_range(0, candidates.size() - 1)];
                  send_item(psrq_pkg::CMD_READ, $urandom, $urandom, read_slot,
                            $urandom_range(0, written_extent[read_slot] - 1));
               end
            end
         end else begin
            send_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
         end
      end
      req_tvalid <= 1'b0;

      // Drain outstanding results, then allow the pipeline to settle
      do @(posedge clock); while (pending_results != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
src/psrq_pkg.sv
src/psrq_ram.sv
src/packet_slot_ring_queue.sv
bench/ring_queue_checker.sv
bench/testbench.sv
